// File: hw/rtl/i2csr_pkg.sv
// package for the i2c slave command responder
// holds beat types, status codes, protocol modes and buffer sizing; no dependencies
package i2csr_pkg;

    // packet buffer sizing
    localparam int PACKET_DEPTH = 256;
    localparam int PKT_AW       = $clog2(PACKET_DEPTH);
    localparam int CNT_W        = $clog2(PACKET_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OPCODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_ADDR_OPCODE = 1'd1;
    localparam logic [7:0] START_OPCODE_RST = 8'h01;
    localparam logic [7:0] SET_ADDR_OPCODE_RST = 8'h02;

    // protocol modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_COMMAND   = 3'd1;
    localparam logic [2:0] MODE_MEASURE   = 3'd2;
    localparam logic [2:0] MODE_WAIT_ADDR = 3'd3;
    localparam logic [2:0] MODE_ADDR_DONE = 3'd4;
    localparam logic [2:0] MODE_TRANSMIT  = 3'd5;

    // slave status codes
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_SLA_W_ACK    = 8'h60;
    localparam logic [7:0] ST_SLA_W_ARB    = 8'h68;
    localparam logic [7:0] ST_GCALL_ACK    = 8'h70;
    localparam logic [7:0] ST_GCALL_ARB    = 8'h78;
    localparam logic [7:0] ST_DATA_ACK     = 8'h80;
    localparam logic [7:0] ST_DATA_NACK    = 8'h88;
    localparam logic [7:0] ST_GDATA_ACK    = 8'h90;
    localparam logic [7:0] ST_GDATA_NACK   = 8'h98;
    localparam logic [7:0] ST_STOP_RESTART = 8'ha0;
    localparam logic [7:0] ST_SLA_R_ACK    = 8'ha8;
    localparam logic [7:0] ST_TX_DATA_ACK  = 8'hb8;
    localparam logic [7:0] ST_TX_DATA_NACK = 8'hc0;
    localparam logic [7:0] ST_TX_LAST_ACK  = 8'hc8;

    // byte sent when nothing valid is available
    localparam logic [7:0] TX_FILL = 8'hff;

    // item kinds
    localparam logic CMD_BUS_EVENT = 1'b0;
    localparam logic CMD_LOAD      = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] bus_status;
        logic [7:0] bus_data;
        logic [7:0] load_index;
        logic [7:0] load_byte;
        logic       load_last;
    } t_in_beat;

    typedef struct packed {
        logic       line_released;
        logic       ack_next;
        logic       stop_recover;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       start_measure;
        logic       address_update;
        logic [7:0] new_address;
        logic [2:0] protocol_state;
    } t_out_beat;

endpackage

// File: hw/rtl/i2csr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module i2csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/i2c_slave_command_responder_top.sv
// top level of the i2c slave command responder
// depends on i2csr_pkg and i2csr_ram
//
// The block takes one item per beat on the input channel, either a bus status event
// or a packet buffer load, and returns exactly one result beat for each. An item is
// registered in the input stage on acceptance, then resolved against the protocol
// state, which updates as the result is registered; a new item is taken every cycle
// unless the receiver stalls the result register. The packet buffer is a 256-entry
// ram read at one address per item; per-entry valid bits make unwritten entries read
// as zero right after reset, so no clearing pass is needed. The user must write the
// opcode registers by the plain write port only while the block is idle, unenforced.
module i2c_slave_command_responder_top
    import i2csr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data
);

    // configuration registers
    logic [7:0] r_start_opcode;
    logic [7:0] r_set_addr_opcode;

    // input stage
    logic     r_s1_vld;
    t_in_beat r_s1;

    // protocol state
    logic [2:0]       r_mode, n_mode;
    logic [CNT_W-1:0] r_read_index, n_read_index;
    logic [CNT_W-1:0] r_pkt_len, n_pkt_len;
    logic [7:0]       r_pending, n_pending;
    logic [PACKET_DEPTH-1:0] r_entry_vld;

    // result stage
    logic      r_out_vld;
    t_out_beat r_out, n_out;
    logic      r_out_mem, n_out_mem;
    logic      r_out_rd_vld;

    // buffer access
    logic              buf_we, buf_re;
    logic [PKT_AW-1:0] buf_waddr, buf_raddr;
    logic [7:0]        buf_rdata;

    logic s1_adv;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_opcode    <= START_OPCODE_RST;
            r_set_addr_opcode <= SET_ADDR_OPCODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_OPCODE:    r_start_opcode    <= i_cfg_data;
                CFG_SET_ADDR_OPCODE: r_set_addr_opcode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
    end

    // item resolution against the protocol state
    always_comb begin
        n_mode       = r_mode;
        n_read_index = r_read_index;
        n_pkt_len    = r_pkt_len;
        n_pending    = r_pending;
        n_out        = '0;
        n_out_mem    = 1'b0;
        buf_we       = 1'b0;
        buf_waddr    = PKT_AW'(r_s1.load_index);
        buf_re       = 1'b0;
        buf_raddr    = '0;

        if (r_s1.command == CMD_LOAD) begin
            // packet buffer load, out-of-range index dropped
            if (32'(r_s1.load_index) < PACKET_DEPTH) begin
                buf_we = 1'b1;
                if (r_s1.load_last) begin
                    n_pkt_len = CNT_W'(32'(r_s1.load_index) + 1);
                end
            end
        end else begin
            unique case (r_s1.bus_status) inside
                ST_SLA_W_ACK, ST_GCALL_ACK: begin
                    n_out.line_released = 1'b1;
                    if (r_mode == MODE_IDLE) begin
                        n_out.ack_next = 1'b1;
                        n_mode         = MODE_COMMAND;
                    end
                end
                ST_SLA_W_ARB, ST_GCALL_ARB: begin
                    n_out.line_released = 1'b1;
                end
                ST_DATA_ACK, ST_GDATA_ACK: begin
                    n_out.line_released = 1'b1;
                    if (r_mode == MODE_COMMAND) begin
                        if (r_s1.bus_data == r_start_opcode) begin
                            n_mode = MODE_MEASURE;
                        end else if (r_s1.bus_data == r_set_addr_opcode) begin
                            n_out.ack_next = 1'b1;
                            n_mode         = MODE_WAIT_ADDR;
                        end else begin
                            n_out.ack_next = 1'b1;
                        end
                    end else if (r_mode == MODE_WAIT_ADDR) begin
                        n_mode    = MODE_ADDR_DONE;
                        n_pending = r_s1.bus_data;
                    end
                end
                ST_DATA_NACK, ST_GDATA_NACK, ST_TX_DATA_NACK, ST_TX_LAST_ACK: begin
                    n_out.line_released = 1'b1;
                    n_out.ack_next      = 1'b1;
                    n_mode              = MODE_IDLE;
                end
                ST_STOP_RESTART: begin
                    n_out.line_released = 1'b1;
                    n_out.ack_next      = 1'b1;
                    if (r_mode == MODE_MEASURE) begin
                        n_out.start_measure = 1'b1;
                    end else if (r_mode == MODE_ADDR_DONE) begin
                        n_out.address_update = 1'b1;
                        n_pkt_len            = '0;
                    end
                    n_mode = MODE_IDLE;
                end
                ST_SLA_R_ACK: begin
                    n_out.line_released = 1'b1;
                    n_out.tx_valid      = 1'b1;
                    if (r_mode == MODE_IDLE) begin
                        n_read_index   = CNT_W'(1);
                        buf_re         = 1'b1;
                        n_out_mem      = 1'b1;
                        n_out.ack_next = 1'b1;
                        n_mode         = MODE_TRANSMIT;
                    end else begin
                        n_out.tx_byte = TX_FILL;
                    end
                end
                ST_TX_DATA_ACK: begin
                    n_out.line_released = 1'b1;
                    n_out.tx_valid      = 1'b1;
                    if (32'(r_read_index) < PACKET_DEPTH) begin
                        buf_re       = 1'b1;
                        buf_raddr    = r_read_index[PKT_AW-1:0];
                        n_out_mem    = 1'b1;
                        n_read_index = r_read_index + CNT_W'(1);
                    end else begin
                        n_out.tx_byte = TX_FILL;
                    end
                    n_out.ack_next = (n_read_index < r_pkt_len);
                end
                ST_BUS_ERROR: begin
                    n_out.line_released = 1'b1;
                    n_out.ack_next      = 1'b1;
                    n_out.stop_recover  = 1'b1;
                    n_mode              = MODE_IDLE;
                end
                default: ;
            endcase
        end

        n_out.new_address    = n_pending;
        n_out.protocol_state = n_mode;
    end

    // protocol state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_read_index <= '0;
            r_pkt_len    <= '0;
            r_pending    <= '0;
            r_entry_vld  <= '0;
        end else if (s1_adv) begin
            r_mode       <= n_mode;
            r_read_index <= n_read_index;
            r_pkt_len    <= n_pkt_len;
            r_pending    <= n_pending;
            if (buf_we) begin
                r_entry_vld[buf_waddr] <= 1'b1;
            end
        end
    end

    // packet buffer
    i2csr_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_DEPTH)
    ) u_pkt_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we && s1_adv),
        .i_waddr (buf_waddr),
        .i_wdata (r_s1.load_byte),
        .i_re    (buf_re && s1_adv),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out        <= n_out;
            r_out_mem    <= n_out_mem;
            r_out_rd_vld <= r_entry_vld[buf_raddr];
        end
    end

    // output beat, buffer byte merged in from the ram read register
    always_comb begin
        o_out_data = r_out;
        if (r_out_mem) begin
            o_out_data.tx_byte = r_out_rd_vld ? buf_rdata : 8'h00;
        end
    end

    assign o_out_valid = r_out_vld;

    // checks
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.tx_valid) |-> (o_out_data.tx_byte == 8'h00))
        else $error("tx_byte nonzero without tx_valid");

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.start_measure && o_out_data.address_update))
        else $error("measure and address update in one beat");

    a_pulse_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.start_measure || o_out_data.address_update
            || o_out_data.stop_recover)) |-> (o_out_data.protocol_state == MODE_IDLE))
        else $error("pulse without return to idle");

    a_read_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_read_index) <= PACKET_DEPTH)
        else $error("read index past packet depth");

    a_addr_update_clears_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && n_out.address_update) |=> (r_pkt_len == '0))
        else $error("packet length not cleared on address change");

endmodule

// File: tb/sv/i2csr_responder_checker.sv
`timescale 1ns / 100ps
// checker for the i2c slave command responder: watches config writes and both channels
// predicts each result beat from its own copy of the protocol state; depends on i2csr_pkg
module i2csr_responder_checker
    import i2csr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_beat             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_beat            i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // opcode registers as last written
    logic [7:0]       start_op;
    logic [7:0]       addr_op;

    // protocol state mirror
    logic [2:0]       mode;
    logic [CNT_W-1:0] rd_idx;
    logic [CNT_W-1:0] pkt_len;
    logic [7:0]       pkt_mem [PACKET_DEPTH];
    logic [7:0]       pending_addr;

    // responses predicted but not yet seen on the output
    t_out_beat        expected_responses [$];
    t_out_beat        want;
    int               mismatches;

    // byte served from the packet buffer, fill byte past its end
    function automatic logic [7:0] buffer_byte(input logic [CNT_W-1:0] idx);
        return (idx < PACKET_DEPTH) ? pkt_mem[idx[PKT_AW-1:0]] : TX_FILL;
    endfunction

    // apply one item to the state and build the response it causes
    function automatic t_out_beat respond_to_item(input t_in_beat item);
        t_out_beat res;
        res = '0;
        if (item.command == CMD_LOAD) begin
            // loads past the buffer end are dropped, length flag included
            if (item.load_index < PACKET_DEPTH) begin
                pkt_mem[item.load_index] = item.load_byte;
                if (item.load_last) begin
                    pkt_len = CNT_W'(item.load_index) + CNT_W'(1);
                end
            end
        end else begin
            case (item.bus_status)
                ST_SLA_W_ACK, ST_GCALL_ACK: begin
                    res.line_released = 1'b1;
                    if (mode == MODE_IDLE) begin
                        res.ack_next = 1'b1;
                        mode = MODE_COMMAND;
                    end
                end
                ST_SLA_W_ARB, ST_GCALL_ARB: begin
                    res.line_released = 1'b1;
                end
                ST_DATA_ACK, ST_GDATA_ACK: begin
                    res.line_released = 1'b1;
                    if (mode == MODE_COMMAND) begin
                        // measurement request wins when both opcodes match
                        if (item.bus_data == start_op) begin
                            mode = MODE_MEASURE;
                        end else begin
                            res.ack_next = 1'b1;
                            if (item.bus_data == addr_op) begin
                                mode = MODE_WAIT_ADDR;
                            end
                        end
                    end else if (mode == MODE_WAIT_ADDR) begin
                        mode = MODE_ADDR_DONE;
                        pending_addr = item.bus_data;
                    end
                end
                ST_DATA_NACK, ST_GDATA_NACK, ST_TX_DATA_NACK, ST_TX_LAST_ACK: begin
                    res.line_released = 1'b1;
                    res.ack_next = 1'b1;
                    mode = MODE_IDLE;
                end
                ST_STOP_RESTART: begin
                    res.line_released = 1'b1;
                    res.ack_next = 1'b1;
                    if (mode == MODE_MEASURE) begin
                        res.start_measure = 1'b1;
                    end else if (mode == MODE_ADDR_DONE) begin
                        res.address_update = 1'b1;
                        pkt_len = '0;
                    end
                    mode = MODE_IDLE;
                end
                ST_SLA_R_ACK: begin
                    res.line_released = 1'b1;
                    res.tx_valid = 1'b1;
                    if (mode == MODE_IDLE) begin
                        rd_idx = CNT_W'(1);
                        res.tx_byte = buffer_byte('0);
                        res.ack_next = 1'b1;
                        mode = MODE_TRANSMIT;
                    end else begin
                        res.tx_byte = TX_FILL;
                    end
                end
                ST_TX_DATA_ACK: begin
                    // served in any mode, index saturates at the buffer depth
                    res.line_released = 1'b1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = buffer_byte(rd_idx);
                    if (rd_idx < PACKET_DEPTH) begin
                        rd_idx = rd_idx + CNT_W'(1);
                    end
                    res.ack_next = (rd_idx < pkt_len);
                end
                ST_BUS_ERROR: begin
                    res.line_released = 1'b1;
                    res.ack_next = 1'b1;
                    res.stop_recover = 1'b1;
                    mode = MODE_IDLE;
                end
                default: begin
                end
            endcase
        end
        res.new_address = pending_addr;
        res.protocol_state = mode;
        return res;
    endfunction

    // one field of a result beat against the prediction
    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            if (mismatches < 10) begin
                $display("mismatch in %s: expected %0h, got %0h", name, exp_v, act_v);
            end
            mismatches++;
        end
    endtask

    // track config, compare result beats, predict from accepted input beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_op = START_OPCODE_RST;
            addr_op = SET_ADDR_OPCODE_RST;
            mode = MODE_IDLE;
            rd_idx = '0;
            pkt_len = '0;
            pending_addr = '0;
            for (int k = 0; k < PACKET_DEPTH; k++) begin
                pkt_mem[k] = '0;
            end
            expected_responses.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_OPCODE) begin
                    start_op = i_cfg_data;
                end else if (i_cfg_idx == CFG_SET_ADDR_OPCODE) begin
                    addr_op = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result beat %0h with nothing outstanding", i_out_data);
                    end
                    mismatches++;
                end else begin
                    want = expected_responses.pop_front();
                    check_field("line_released", 8'(want.line_released),
                                8'(i_out_data.line_released));
                    check_field("ack_next", 8'(want.ack_next), 8'(i_out_data.ack_next));
                    check_field("stop_recover", 8'(want.stop_recover),
                                8'(i_out_data.stop_recover));
                    check_field("tx_valid", 8'(want.tx_valid), 8'(i_out_data.tx_valid));
                    check_field("tx_byte", want.tx_byte, i_out_data.tx_byte);
                    check_field("start_measure", 8'(want.start_measure),
                                8'(i_out_data.start_measure));
                    check_field("address_update", 8'(want.address_update),
                                8'(i_out_data.address_update));
                    check_field("new_address", want.new_address, i_out_data.new_address);
                    check_field("protocol_state", 8'(want.protocol_state),
                                8'(i_out_data.protocol_state));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_responses.push_back(respond_to_item(i_in_data));
            end
        end
        o_fail_count = mismatches;
        o_pending = expected_responses.size();
    end

endmodule

// File: tb/sv/i2c_slave_command_responder_top_tb.sv
`timescale 1ns / 100ps
// testbench top for the i2c slave command responder: clock, reset, stimulus, verdict
// depends on i2csr_pkg, i2c_slave_command_responder_top and i2csr_responder_checker
module i2c_slave_command_responder_top_tb;
    import i2csr_pkg::*;

    // status codes the block leaves unserviced
    localparam logic [7:0] ST_ARB_LOST_SLA_R = 8'hb0;
    localparam logic [7:0] ST_NO_INFO        = 8'hf8;
    localparam logic [7:0] ST_UNDEFINED      = 8'hff;

    localparam int ITEMS_PER_PHASE = 260;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_beat             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_beat            o_out_data;

    int                   fail_count;
    int                   pending_count;
    int                   items_sent;
    logic [7:0]           start_op;
    logic [7:0]           addr_op;
    bit                   steady;
    bit                   hold_go;
    bit                   hold_done;

    i2c_slave_command_responder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    i2csr_responder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #18_000_000;
        $display("i2c_slave_command_responder_top_tb failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // bus event beat, load fields random since the block must ignore them
    function automatic t_in_beat bus_event(input logic [7:0] status, input logic [7:0] data);
        t_in_beat b;
        b.command    = CMD_BUS_EVENT;
        b.bus_status = status;
        b.bus_data   = data;
        b.load_index = rand_byte();
        b.load_byte  = rand_byte();
        b.load_last  = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // packet load beat, event fields random
    function automatic t_in_beat load_item(input logic [7:0] idx, input logic [7:0] val,
                                           input logic last);
        t_in_beat b;
        b.command    = CMD_LOAD;
        b.bus_status = rand_byte();
        b.bus_data   = rand_byte();
        b.load_index = idx;
        b.load_byte  = val;
        b.load_last  = last;
        return b;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 15))
            0:       return ST_BUS_ERROR;
            1:       return ST_SLA_W_ACK;
            2:       return ST_SLA_W_ARB;
            3:       return ST_GCALL_ACK;
            4:       return ST_GCALL_ARB;
            5:       return ST_DATA_ACK;
            6:       return ST_DATA_NACK;
            7:       return ST_GDATA_ACK;
            8:       return ST_GDATA_NACK;
            9:       return ST_STOP_RESTART;
            10:      return ST_SLA_R_ACK;
            11:      return ST_TX_DATA_ACK;
            12:      return ST_TX_DATA_NACK;
            13:      return ST_TX_LAST_ACK;
            14:      return ST_ARB_LOST_SLA_R;
            default: return ST_NO_INFO;
        endcase
    endfunction

    function automatic logic [7:0] pick_sla_w();
        return $urandom_range(0, 1) ? ST_SLA_W_ACK : ST_GCALL_ACK;
    endfunction

    function automatic logic [7:0] pick_data_ack();
        return $urandom_range(0, 1) ? ST_DATA_ACK : ST_GDATA_ACK;
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_beat(input t_in_beat item);
        int gap;
        gap = (steady || (hold_go && !hold_done)) ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // wait until every predicted result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_opcodes(input logic [7:0] start_v, input logic [7:0] addr_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_OPCODE;
        i_cfg_data <= start_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SET_ADDR_OPCODE;
        i_cfg_data <= addr_v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        start_op = start_v;
        addr_op  = addr_v;
    endtask

    // slave transmit: address match, data bytes served, closing status
    task automatic run_read(input int count);
        int k;
        send_beat(bus_event(ST_SLA_R_ACK, rand_byte()));
        for (k = 0; k < count; k++) begin
            send_beat(bus_event(ST_TX_DATA_ACK, rand_byte()));
        end
        send_beat(bus_event($urandom_range(0, 1) ? ST_TX_DATA_NACK : ST_TX_LAST_ACK,
                            rand_byte()));
    endtask

    // one random transaction, mostly well formed, some noise
    task automatic run_sequence();
        int         kind;
        int         n;
        int         k;
        int         r;
        logic [7:0] cmd;
        kind = $urandom_range(0, 99);
        steady = ($urandom_range(0, 9) == 0);
        if (kind < 22) begin
            // write transaction with command bytes
            send_beat(bus_event(pick_sla_w(), rand_byte()));
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                r = $urandom_range(0, 9);
                cmd = (r < 4) ? start_op : ((r < 7) ? addr_op : rand_byte());
                send_beat(bus_event(pick_data_ack(), cmd));
            end
            r = $urandom_range(0, 9);
            send_beat(bus_event((r < 6) ? ST_STOP_RESTART :
                                ((r < 8) ? ST_DATA_NACK : ST_GDATA_NACK), rand_byte()));
        end else if (kind < 38) begin
            // address change
            send_beat(bus_event(pick_sla_w(), rand_byte()));
            send_beat(bus_event(pick_data_ack(), addr_op));
            send_beat(bus_event(pick_data_ack(), rand_byte()));
            if ($urandom_range(0, 4) == 0) begin
                send_beat(bus_event(pick_data_ack(), rand_byte()));
            end
            send_beat(bus_event(($urandom_range(0, 4) != 0) ? ST_STOP_RESTART : ST_DATA_NACK,
                                rand_byte()));
        end else if (kind < 62) begin
            // optional packet load from the start, then a read
            if ($urandom_range(0, 1)) begin
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++) begin
                    send_beat(load_item(8'(k), rand_byte(), k == n - 1));
                end
            end
            run_read($urandom_range(0, 16));
        end else if (kind < 76) begin
            // scattered loads
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
                send_beat(load_item(8'($urandom_range(0, 1) ? $urandom_range(0, 15) :
                                       $urandom_range(0, 255)),
                                    rand_byte(), $urandom_range(0, 9) < 3));
            end
        end else begin
            // noise: any status code, known codes out of order, stray loads
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    send_beat(bus_event(rand_byte(), rand_byte()));
                end else if (r == 1) begin
                    send_beat(bus_event(pick_code(), rand_byte()));
                end else begin
                    send_beat(load_item(rand_byte(), rand_byte(), 1'($urandom_range(0, 1))));
                end
            end
        end
        steady = 1'b0;
    endtask

    // receiver: random stalls, long ready runs, one long hold-off on request
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_go && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                  $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int phase;
        int target;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        items_sent = 0;
        start_op   = START_OPCODE_RST;
        addr_op    = SET_ADDR_OPCODE_RST;
        steady     = 1'b0;
        hold_go    = 1'b0;
        hold_done  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: buffer extremes, full-length packet, then each status code
        send_beat(load_item(8'h00, 8'hff, 1'b0));
        send_beat(load_item(8'hff, 8'h00, 1'b1));
        send_beat(load_item(8'h01, 8'ha5, 1'b0));
        send_beat(bus_event(ST_SLA_R_ACK, 8'h00));
        send_beat(bus_event(ST_TX_DATA_ACK, 8'hff));
        send_beat(bus_event(ST_TX_LAST_ACK, 8'h00));
        // measurement request
        send_beat(bus_event(ST_SLA_W_ACK, 8'hff));
        send_beat(bus_event(ST_DATA_ACK, START_OPCODE_RST));
        send_beat(bus_event(ST_STOP_RESTART, 8'h00));
        // address change through the general call path
        send_beat(bus_event(ST_GCALL_ACK, 8'h00));
        send_beat(bus_event(ST_GDATA_ACK, SET_ADDR_OPCODE_RST));
        send_beat(bus_event(ST_GDATA_ACK, 8'hff));
        send_beat(bus_event(ST_STOP_RESTART, 8'hff));
        // unknown command byte, read request outside idle
        send_beat(bus_event(ST_SLA_W_ACK, 8'h00));
        send_beat(bus_event(ST_DATA_ACK, 8'h00));
        send_beat(bus_event(ST_SLA_R_ACK, 8'h00));
        send_beat(bus_event(ST_DATA_NACK, 8'h00));
        // arbitration lost and remaining codes
        send_beat(bus_event(ST_SLA_W_ARB, 8'hff));
        send_beat(bus_event(ST_GCALL_ARB, 8'h00));
        send_beat(bus_event(ST_GDATA_NACK, 8'hff));
        send_beat(bus_event(ST_TX_DATA_ACK, 8'h00));
        send_beat(bus_event(ST_ARB_LOST_SLA_R, 8'hff));
        send_beat(bus_event(ST_NO_INFO, 8'h00));
        send_beat(bus_event(ST_UNDEFINED, 8'hff));
        send_beat(bus_event(ST_BUS_ERROR, 8'h00));
        send_beat(bus_event(ST_TX_DATA_NACK, 8'hff));

        // random phases, each under its own opcode setting
        for (phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1:       set_opcodes(8'h00, 8'hff);
                    2:       set_opcodes(8'hff, 8'h00);
                    3:       set_opcodes(8'h5a, 8'h5a);
                    default: set_opcodes(rand_byte(), rand_byte());
                endcase
            end
            // read running past the end of the buffer
            if (phase == 1) begin
                run_read(258);
            end
            // back-to-back beats while the receiver holds off
            if (phase == 2) begin
                hold_go = 1'b1;
                while (!hold_done) begin
                    send_beat(bus_event(pick_code(), rand_byte()));
                end
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                run_sequence();
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("i2c_slave_command_responder_top_tb passed");
        end else begin
            $display("i2c_slave_command_responder_top_tb failed");
        end
        $finish;
    end

endmodule
